// ===== hdl/tkl_pkg.sv =====
// tkl_pkg: shared types, constants and helpers for the top-k insertion list
// used by the interfaces, the list cells, the read-out sequencer and the top level
`default_nettype none

package tkl_pkg;

  // list depth and derived widths
  localparam int MAX_K   = 16;
  localparam int IDX_W   = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int KW      = $clog2(MAX_K + 1);

  // payload widths
  localparam int ACT_W   = 2;
  localparam int ID_W    = 20;
  localparam int SCORE_W = 32;
  localparam int RANK_W  = 4;
  localparam int KREG_W  = 5;

  // configuration port
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;
  localparam int K_RESET = (MAX_K < 16) ? MAX_K : 16;

  // action codes
  typedef enum logic [ACT_W-1:0] {
    ACT_ADD   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_READ  = 2'd2
  } action_t;

  // register indexes
  typedef enum logic [0:0] {
    REG_K_IN_USE = 1'b0
  } reg_idx_t;

  // contents of one list cell
  typedef struct packed {
    logic                      valid;
    logic [ID_W-1:0]           id;
    logic signed [SCORE_W-1:0] score;
  } cell_data_t;

  // candidate and command broadcast to every cell
  typedef struct packed {
    logic                      add;
    logic                      clr;
    logic [ID_W-1:0]           id;
    logic signed [SCORE_W-1:0] score;
  } bcast_t;

  // per-cell control from the top level
  typedef struct packed {
    logic en;   // cell lies below k_in_use
    logic cut;  // cell is dropped by a lowering config write
  } cell_ctl_t;

  // map a written register value onto 1..MAX_K
  function automatic logic [KW-1:0] k_clamp(input logic [KREG_W-1:0] v);
    logic [KW-1:0] k;
    if (v == '0) begin
      k = KW'(1);
    end else if (int'(v) > MAX_K) begin
      k = KW'(MAX_K);
    end else begin
      k = KW'(v);
    end
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/tkl_in_if.sv =====
// tkl_in_if: command channel into the top-k list (valid/ready plus payload)
// depends on tkl_pkg for field widths
`default_nettype none

interface tkl_in_if;
  logic                               valid;
  logic                               ready;
  logic [tkl_pkg::ACT_W-1:0]          action;
  logic [tkl_pkg::ID_W-1:0]           entry_id;
  logic signed [tkl_pkg::SCORE_W-1:0] score;

  modport source (output valid, action, entry_id, score, input ready);
  modport sink   (input valid, action, entry_id, score, output ready);
endinterface

`default_nettype wire

// ===== hdl/tkl_out_if.sv =====
// tkl_out_if: result channel out of the top-k list (valid/ready plus payload)
// depends on tkl_pkg for field widths
`default_nettype none

interface tkl_out_if;
  logic                               valid;
  logic                               ready;
  logic [tkl_pkg::RANK_W-1:0]         rank;
  logic                               slot_valid;
  logic [tkl_pkg::ID_W-1:0]           out_id;
  logic signed [tkl_pkg::SCORE_W-1:0] out_score;
  logic                               last;

  modport source (output valid, rank, slot_valid, out_id, out_score, last, input ready);
  modport sink   (input valid, rank, slot_valid, out_id, out_score, last, output ready);
endinterface

`default_nettype wire

// ===== hdl/tkl_cell.sv =====
// tkl_cell: one rank of the sorted list, compares against the candidate and
// either holds, takes the candidate, takes its upper neighbor or is emptied; uses tkl_pkg
`default_nettype none

module tkl_cell (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire tkl_pkg::bcast_t     bc,
  input  wire tkl_pkg::cell_ctl_t  ctl,
  input  wire logic                prev_keep,
  input  wire tkl_pkg::cell_data_t prev_data,
  output tkl_pkg::cell_data_t      data,
  output logic                     keep
);

  tkl_pkg::cell_data_t data_r;
  tkl_pkg::cell_data_t data_nxt;

  // entry stays in place when it scores at least the candidate
  assign keep = data_r.valid && (data_r.score >= bc.score);
  assign data = data_r;

  // insertion decision
  always_comb begin
    data_nxt = data_r;
    if (bc.clr || ctl.cut) begin
      data_nxt.valid = 1'b0;
    end else if (bc.add && ctl.en && !keep) begin
      if (prev_keep) begin
        data_nxt.valid = 1'b1;
        data_nxt.id    = bc.id;
        data_nxt.score = bc.score;
      end else begin
        data_nxt = prev_data;
      end
    end
  end

  // payload, and the valid flag which alone is reset
  always_ff @(posedge clk) begin
    data_r.id    <= data_nxt.id;
    data_r.score <= data_nxt.score;
    if (!rst_n) begin
      data_r.valid <= 1'b0;
    end else begin
      data_r.valid <= data_nxt.valid;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/tkl_readout.sv =====
// tkl_readout: walks ranks 0..k_in_use-1 and drives the result register
// depends on tkl_pkg and tkl_out_if
`default_nettype none

module tkl_readout (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic [tkl_pkg::KW-1:0]  k_in_use,
  input  wire tkl_pkg::cell_data_t     cells [tkl_pkg::MAX_K],
  output logic                         busy,
  tkl_out_if.source                    out_ch
);

  logic                               busy_r;
  logic [tkl_pkg::IDX_W-1:0]          idx_r;
  logic                               ov_r;
  logic [tkl_pkg::RANK_W-1:0]         rank_r;
  logic                               sv_r;
  logic [tkl_pkg::ID_W-1:0]           id_r;
  logic signed [tkl_pkg::SCORE_W-1:0] score_r;
  logic                               last_r;

  logic                               load;
  logic                               at_last;
  tkl_pkg::cell_data_t                sel;

  assign load    = busy_r && (!ov_r || out_ch.ready);
  assign at_last = (tkl_pkg::KW'(idx_r) + tkl_pkg::KW'(1)) == k_in_use;
  assign sel     = cells[idx_r];

  // sequencer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      if (start) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (load) begin
        if (at_last) begin
          busy_r <= 1'b0;
        end
        idx_r <= idx_r + tkl_pkg::IDX_W'(1);
      end
      if (load) begin
        ov_r <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // result register, empty ranks read as zero
  always_ff @(posedge clk) begin
    if (load) begin
      rank_r  <= tkl_pkg::RANK_W'(idx_r);
      sv_r    <= sel.valid;
      id_r    <= sel.valid ? sel.id : '0;
      score_r <= sel.valid ? sel.score : '0;
      last_r  <= at_last;
    end
  end

  assign busy              = busy_r;
  assign out_ch.valid      = ov_r;
  assign out_ch.rank       = rank_r;
  assign out_ch.slot_valid = sv_r;
  assign out_ch.out_id     = id_r;
  assign out_ch.out_score  = score_r;
  assign out_ch.last       = last_r;

endmodule

`default_nettype wire

// ===== hdl/top_k_insertion_list.sv =====
// top_k_insertion_list: running list of the k best (id, score) pairs, best first
// depends on tkl_pkg, tkl_in_if, tkl_out_if, tkl_cell and tkl_readout
//
// Usage:
//   in_ch carries one command beat: add (entry_id, score), clear, or read out.
//   Scores are signed Q2.30 and compared as signed integers; ties keep arrival
//   order. Add and clear give no result, so adds can stream at one beat per cycle
//   through the row of compare-and-shift cells while no read out holds the input.
//   A read out gives k_in_use result beats on out_ch, rank 0 first, the last one
//   flagged; the read sequencer starts, loads the first beat into the result
//   register, then loads one beat per cycle while out_ch.ready is high.
//   in_ch.ready stays low from the read command until the final beat is loaded
//   into the output register, so a read holds the input through any receiver stall.
//   A stalled receiver holds the result register; the read sequencer waits.
//   k_in_use is written over the APB-style cfg port at byte address 0; values
//   of 0 act as 1 and values above MAX_K as MAX_K; lowering it drops the
//   entries at or beyond the new value. Write it only while the block is idle.
//   Reset (rst_n low, synchronous) empties the list and sets k_in_use to 16.
`default_nettype none

module top_k_insertion_list (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  tkl_in_if.sink                            in_ch,
  tkl_out_if.source                         out_ch,
  input  wire logic                         cfg_psel,
  input  wire logic                         cfg_penable,
  input  wire logic                         cfg_pwrite,
  input  wire logic [tkl_pkg::APB_AW-1:0]   cfg_paddr,
  input  wire logic [tkl_pkg::APB_DW-1:0]   cfg_pwdata,
  output logic      [tkl_pkg::APB_DW-1:0]   cfg_prdata,
  output logic                              cfg_pready
);

  logic [tkl_pkg::KW-1:0]    k_r;
  logic [tkl_pkg::KW-1:0]    k_new;
  logic                      cfg_wr;
  logic                      in_acc;
  logic                      rd_busy;
  tkl_pkg::bcast_t           bc;
  tkl_pkg::cell_ctl_t        ctl   [tkl_pkg::MAX_K];
  tkl_pkg::cell_data_t       cells [tkl_pkg::MAX_K];
  logic [tkl_pkg::MAX_K-1:0] keep;
  logic [tkl_pkg::MAX_K-1:0] vbits;
  logic [tkl_pkg::MAX_K-1:0] kmask;

  // config port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[2] == tkl_pkg::REG_K_IN_USE);
  assign k_new      = tkl_pkg::k_clamp(cfg_pwdata[tkl_pkg::KREG_W-1:0]);
  assign cfg_prdata = (cfg_paddr[2] == tkl_pkg::REG_K_IN_USE) ?
                      tkl_pkg::APB_DW'(k_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= tkl_pkg::KW'(tkl_pkg::K_RESET);
    end else if (cfg_wr) begin
      k_r <= k_new;
    end
  end

  // command decode and broadcast
  assign in_ch.ready = !rd_busy;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign bc.add      = in_acc && (in_ch.action == tkl_pkg::ACT_ADD);
  assign bc.clr      = in_acc && (in_ch.action == tkl_pkg::ACT_CLEAR);
  assign bc.id       = in_ch.entry_id;
  assign bc.score    = in_ch.score;

  // row of cells
  for (genvar i = 0; i < tkl_pkg::MAX_K; i++) begin : g_cell
    assign ctl[i].en  = tkl_pkg::KW'(i) < k_r;
    assign ctl[i].cut = cfg_wr && (tkl_pkg::KW'(i) >= k_new);
    assign vbits[i]   = cells[i].valid;
    assign kmask[i]   = ctl[i].en;
    if (i == 0) begin : g_head
      tkl_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .bc        (bc),
        .ctl       (ctl[i]),
        .prev_keep (1'b1),
        .prev_data (cells[i]),
        .data      (cells[i]),
        .keep      (keep[i])
      );
    end else begin : g_body
      tkl_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .bc        (bc),
        .ctl       (ctl[i]),
        .prev_keep (keep[i-1]),
        .prev_data (cells[i-1]),
        .data      (cells[i]),
        .keep      (keep[i])
      );
    end
  end

  // read-out sequencer and result register
  tkl_readout u_readout (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc && (in_ch.action == tkl_pkg::ACT_READ)),
    .k_in_use (k_r),
    .cells    (cells),
    .busy     (rd_busy),
    .out_ch   (out_ch)
  );

  // valid entries always fill ranks from the top with no gaps
  a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot({1'b0, vbits} + (tkl_pkg::MAX_K + 1)'(1)))
    else $error("list holds a gap");

  // nothing valid at or beyond k_in_use
  a_within_k: assert property (@(posedge clk) disable iff (!rst_n)
    (vbits & ~kmask) == '0)
    else $error("entry beyond k_in_use");

  // a clear empties every cell
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    bc.clr |=> (vbits == '0))
    else $error("clear left entries");

  // the input is freed only once the final beat sits in the result register
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(rd_busy) |-> (out_ch.valid && out_ch.last))
    else $error("read-out freed the input without its last beat");

endmodule

`default_nettype wire

// ===== tb/top_k_insertion_list_tb.sv =====
// top_k_insertion_list_tb: self-checking bench for the running top-k list
// depends on tkl_pkg, tkl_in_if, tkl_out_if and the top_k_insertion_list rtl
`timescale 1ns / 1ps

module top_k_insertion_list_tb;
  import tkl_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 300;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 60;
  localparam int IDLE_SETTLE = 4;

  // spare action code that the block must ignore
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  localparam logic signed [SCORE_W-1:0] SCORE_MAX     = 32'sh7FFF_FFFF;
  localparam logic signed [SCORE_W-1:0] SCORE_MIN     = 32'sh8000_0000;
  localparam logic signed [SCORE_W-1:0] SCORE_NEG_ONE = -32'sd1;
  localparam logic [ID_W-1:0]           ID_MAX        = '1;

  // one read-out beat as seen on the result channel
  typedef struct packed {
    logic [RANK_W-1:0]         rank;
    logic                      slot_valid;
    logic [ID_W-1:0]           id;
    logic signed [SCORE_W-1:0] score;
    logic                      last;
  } rank_beat_t;

  // running top-k ranking and the read-out beats still owed by the block
  class topk_ranking;
    logic [ID_W-1:0]           ids    [MAX_K];
    logic signed [SCORE_W-1:0] scores [MAX_K];
    bit                        held   [MAX_K];
    int                        fill;
    int                        k;
    rank_beat_t                ranked_beats_due [$];
    int                        errors;
    int                        commands;
    int                        beats_checked;

    function new();
      wipe_from(0);
      fill          = 0;
      k             = K_RESET;
      errors        = 0;
      commands      = 0;
      beats_checked = 0;
    endfunction

    function void wipe_from(int first);
      for (int i = first; i < MAX_K; i++) begin
        ids[i]    = '0;
        scores[i] = '0;
        held[i]   = 1'b0;
      end
    endfunction

    // register write: 0 acts as 1, above the depth acts as the depth
    function void set_k(logic [KREG_W-1:0] v);
      if (v == '0) begin
        k = 1;
      end else if (int'(v) > MAX_K) begin
        k = MAX_K;
      end else begin
        k = int'(v);
      end
      if (fill > k) fill = k;
      wipe_from(k);
    endfunction

    // place behind every entry with score >= candidate, drop what falls off
    function void insert_candidate(logic [ID_W-1:0] id, logic signed [SCORE_W-1:0] sc);
      int pos;
      int tail;
      pos = 0;
      while (pos < fill && scores[pos] >= sc) pos++;
      if (pos >= k) return;
      tail = (fill < k) ? fill : k - 1;
      for (int i = tail; i > pos; i--) begin
        ids[i]    = ids[i-1];
        scores[i] = scores[i-1];
        held[i]   = held[i-1];
      end
      ids[pos]    = id;
      scores[pos] = sc;
      held[pos]   = 1'b1;
      if (fill < k) fill++;
    endfunction

    function void read_out();
      rank_beat_t b;
      for (int r = 0; r < k; r++) begin
        b.rank       = RANK_W'(r);
        b.slot_valid = (r < fill) && held[r];
        b.id         = b.slot_valid ? ids[r] : '0;
        b.score      = b.slot_valid ? scores[r] : '0;
        b.last       = (r + 1 == k);
        ranked_beats_due.insert(ranked_beats_due.size(), b);
      end
    endfunction

    // accepted command beat
    function void take_command(logic [ACT_W-1:0] act, logic [ID_W-1:0] id,
                               logic signed [SCORE_W-1:0] sc);
      commands++;
      case (act)
        ACT_ADD:   insert_candidate(id, sc);
        ACT_CLEAR: begin
          wipe_from(0);
          fill = 0;
        end
        ACT_READ:  read_out();
        default:   ;
      endcase
    endfunction

    function void compare_field(string name, logic [SCORE_W-1:0] e, logic [SCORE_W-1:0] a);
      if (e !== a) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, e, a);
      end
    endfunction

    // accepted result beat against the oldest one owed
    function void check_beat(rank_beat_t got);
      rank_beat_t want;
      if (ranked_beats_due.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected, expected none actual rank %0d",
                 $time, got.rank);
        return;
      end
      want = ranked_beats_due.pop_front();
      beats_checked++;
      compare_field("rank",       want.rank,       got.rank);
      compare_field("slot_valid", want.slot_valid, got.slot_valid);
      compare_field("out_id",     want.id,         got.id);
      compare_field("out_score",  want.score,      got.score);
      compare_field("last",       want.last,       got.last);
    endfunction

    function int pending();
      return ranked_beats_due.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [APB_AW-1:0] cfg_paddr;
  logic [APB_DW-1:0] cfg_pwdata;
  logic [APB_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  tkl_in_if  in_ch ();
  tkl_out_if out_ch ();

  topk_ranking sb;

  // receiver controls, driven by the main sequence
  logic rx_burst;
  logic hold_toggle;
  int   cycle_count;
  int   sizes_used;

  top_k_insertion_list dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // result side: random stalls per beat plus one long hold-off on request
  int   rx_wait;
  int   rx_long;
  logic hold_seen;
  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready) rx_wait = rx_burst ? 0 : $urandom_range(0, 14);
    if (hold_toggle != hold_seen) begin
      hold_seen = hold_toggle;
      rx_long   = LONG_HOLD;
    end
    if (rx_long > 0) begin
      rx_long--;
      out_ch.ready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    rank_beat_t got;
    if (rst_n && sb != null && out_ch.valid && out_ch.ready) begin
      got.rank       = out_ch.rank;
      got.slot_valid = out_ch.slot_valid;
      got.id         = out_ch.out_id;
      got.score      = out_ch.out_score;
      got.last       = out_ch.last;
      sb.check_beat(got);
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // one command beat; valid stays high across back-to-back beats
  task automatic send_item(input logic [ACT_W-1:0] act, input logic [ID_W-1:0] id,
                           input logic signed [SCORE_W-1:0] sc, input bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.action   <= act;
    in_ch.entry_id <= id;
    in_ch.score    <= sc;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.take_command(act, id, sc);
  endtask

  // stop offering and let every owed beat arrive, then let adds settle
  task automatic drain_idle();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  // register write: setup beat then access beat
  task automatic write_k(input logic [KREG_W-1:0] v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= APB_AW'(4 * int'(REG_K_IN_USE));
    cfg_pwdata  <= APB_DW'(v);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.set_k(v);
    sizes_used++;
  endtask

  // mostly adds, with reads, clears and the spare code mixed in
  function automatic logic [ACT_W-1:0] pick_action();
    int p;
    p = $urandom_range(0, 99);
    if (p < 75) return ACT_ADD;
    if (p < 89) return ACT_READ;
    if (p < 95) return ACT_CLEAR;
    return ACT_UNUSED;
  endfunction

  // full range, extremes, and a narrow band that forces ties
  function automatic logic signed [SCORE_W-1:0] pick_score();
    int sel;
    int t;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return SCORE_MAX;
      1: return SCORE_MIN;
      2, 3, 4: begin
        t = int'($urandom_range(0, 8)) - 4;
        return t;
      end
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [KREG_W-1:0] k_plan [PHASES];
    bit tx_burst;

    clk            = 1'b0;
    rst_n          = 1'b0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    in_ch.valid    = 1'b0;
    in_ch.action   = ACT_ADD;
    in_ch.entry_id = '0;
    in_ch.score    = '0;
    out_ch.ready   = 1'b1;
    rx_burst       = 1'b0;
    hold_toggle    = 1'b0;
    hold_seen      = 1'b0;
    rx_wait        = 0;
    rx_long        = 0;
    sizes_used     = 0;
    sb             = new();

    // reset
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty list, extremes, ties, spare code, clear
    send_item(ACT_READ, '0, '0, 0);
    send_item(ACT_ADD, ID_MAX, SCORE_MAX, 0);
    send_item(ACT_ADD, 20'd0, SCORE_MIN, 0);
    send_item(ACT_ADD, 20'd1, '0, 1);
    send_item(ACT_ADD, 20'd2, SCORE_NEG_ONE, 1);
    send_item(ACT_ADD, 20'd3, SCORE_NEG_ONE, 0);
    send_item(ACT_ADD, 20'd4, SCORE_MAX, 1);
    send_item(ACT_UNUSED, ID_MAX, SCORE_MIN, 0);
    send_item(ACT_READ, '0, '0, 0);
    send_item(ACT_CLEAR, ID_MAX, SCORE_MAX, 1);
    send_item(ACT_READ, '0, '0, 1);
    for (int i = 0; i < 5; i++) send_item(ACT_ADD, ID_W'(10 + i), 50 - 10 * i, 1);

    // lowering the size drops the tail, raising it keeps what is held
    drain_idle();
    write_k(5'd3);
    send_item(ACT_READ, '0, '0, 0);
    drain_idle();
    write_k(5'd8);
    send_item(ACT_READ, '0, '0, 1);
    send_item(ACT_ADD, 20'd20, 32'sd5, 1);
    send_item(ACT_ADD, 20'd21, 32'sd25, 0);
    send_item(ACT_READ, '0, '0, 0);

    // size 0 acts as one slot: a tie does not displace the holder
    drain_idle();
    write_k(5'd0);
    send_item(ACT_ADD, 20'd30, 32'sd60, 0);
    send_item(ACT_ADD, 20'd31, 32'sd60, 1);
    send_item(ACT_READ, '0, '0, 1);

    // oversized write acts as the full depth
    drain_idle();
    write_k(5'd31);
    send_item(ACT_READ, '0, '0, 0);

    // random phases over several list sizes
    k_plan = '{5'd16, 5'd1, 5'd5, 5'd0, 5'd31, 5'd2, KREG_W'($urandom_range(1, 16)), 5'd16};
    for (int p = 0; p < PHASES; p++) begin
      drain_idle();
      write_k(k_plan[p]);
      tx_burst = (p == 0) || (p % 3 == 2);
      rx_burst <= (p % 3 == 1);
      // long receiver hold-off while commands keep coming
      if (p == 0) hold_toggle <= ~hold_toggle;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // sender waits for every owed beat once
        if (p == 3 && n == PHASE_ITEMS / 2) begin
          in_ch.valid <= 1'b0;
          do @(posedge clk); while (sb.pending() != 0);
        end
        send_item(pick_action(), ID_W'($urandom), pick_score(), tx_burst);
      end
    end

    // wind down
    drain_idle();
    repeat (20) @(posedge clk);
    $display("summary: %0d commands, %0d result beats checked over %0d size writes",
             sb.commands, sb.beats_checked, sizes_used);
    $display("summary: covered ties, score extremes, clears, spare code and a long stall");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
